[rtl/core/mesh_wormhole_router_unit_assert.svh]
// Assertion macros for the router core.
`ifndef MESH_WORMHOLE_ROUTER_UNIT_ASSERT_SVH
`define MESH_WORMHOLE_ROUTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MWR_ASSERT(label, prop, msg)
`define MWR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/core/mwr_pkg.sv]
package mwr_pkg;

  localparam int PORTS      = 5;
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = 5;
  localparam int MAX_BURST  = 4;
  localparam int MEM_DEPTH  = PORTS * FIFO_DEPTH;
  localparam int MEM_AW     = 8;

  localparam logic [2:0] LOCAL_PORT = 3'd4;
  localparam logic [3:0] NO_PORT    = 4'hF;

  localparam logic [1:0] OP_FLIT   = 2'd0;
  localparam logic [1:0] OP_CREDIT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_FLIT  = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_CREDIT   = 2'd2;
  localparam logic [1:0] ST_BAD_DEST = 2'd3;

  localparam logic [2:0] REG_ROUTER_INDEX = 3'd0;
  localparam logic [2:0] REG_COLUMNS      = 3'd1;
  localparam logic [2:0] REG_ROWS         = 3'd2;
  localparam logic [2:0] REG_BUF_LIMIT    = 3'd3;
  localparam logic [2:0] REG_HEAD_DELAY   = 3'd4;
  localparam logic [2:0] REG_FPC          = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  port;
    logic        is_head;
    logic        is_tail;
    logic [7:0]  dest_node;
    logic [31:0] payload;
    logic [5:0]  credit_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  out_port;
    logic [2:0]  credit_port;
    logic [31:0] out_payload;
    logic [7:0]  out_dest;
    logic        out_head;
    logic        out_tail;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        head;
    logic        tail;
    logic [7:0]  dest;
    logic [31:0] data;
    logic [31:0] stamp;
  } fentry_t;

endpackage

[rtl/core/mwr_div.sv]
module mwr_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] dividend,
  input  logic [4:0] divisor,
  output logic       done,
  output logic [7:0] quot,
  output logic [4:0] rem
);

  logic       run_r, run_nxt;
  logic       done_r, done_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] q_r, q_nxt;
  logic [4:0] r_r, r_nxt;
  logic [4:0] d_r, d_nxt;
  logic [5:0] trial;

  assign trial = {r_r, q_r[7]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = 4'd0;
      q_nxt   = dividend;
      r_nxt   = 5'd0;
      d_nxt   = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = 5'(trial - {1'b0, d_r});
        q_nxt = {q_r[6:0], 1'b1};
      end else begin
        r_nxt = trial[4:0];
        q_nxt = {q_r[6:0], 1'b0};
      end
      cnt_nxt = 4'(cnt_r + 4'd1);
      if (cnt_r == 4'd7) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

[rtl/core/mwr_fmem.sv]
module mwr_fmem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mwr_pkg::MEM_AW-1:0] wr_addr,
  input  mwr_pkg::fentry_t           wr_data,
  input  logic                       rd_en,
  input  logic [mwr_pkg::MEM_AW-1:0] rd_addr,
  output mwr_pkg::fentry_t           rd_data
);

  mwr_pkg::fentry_t mem [mwr_pkg::MEM_DEPTH];
  mwr_pkg::fentry_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule

[rtl/core/mesh_wormhole_router_unit.sv]
// Channel   Handshake             Payload
// input     start / busy          in_item  (opcode, port, flit, credits)
// result    out_valid, one cycle  out_item (kind, status, flit, last)
// config    psel/penable/pwrite   paddr, pwdata, prdata; pready tied high
// Arrival and credit items: busy covers only the execute state, which registers the result.
// A tick keeps busy while one shared 8-bit serial divider resolves the router
// column and then each input's front destination, and while outputs are
// granted and flits are forwarded.
// Synchronous rst_n clears FIFO state, ownership, counters; sets credits to 32.
// Results cannot be stalled; busy drops in the cycle the last result is presented.
module mesh_wormhole_router_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mwr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output mwr_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_RDIV_GO = 4'd2;
  localparam logic [3:0] S_RDIV_W  = 4'd3;
  localparam logic [3:0] S_FRD     = 4'd4;
  localparam logic [3:0] S_FCAP    = 4'd5;
  localparam logic [3:0] S_FDIV_W  = 4'd6;
  localparam logic [3:0] S_SEL     = 4'd7;
  localparam logic [3:0] S_OSTART  = 4'd8;
  localparam logic [3:0] S_SRD     = 4'd9;
  localparam logic [3:0] S_SCHK    = 4'd10;
  localparam logic [3:0] S_TEND    = 4'd11;

  localparam int P = mwr_pkg::PORTS;

  logic [7:0] router_index_r;
  logic [4:0] cols_r, rows_r;
  logic [5:0] buf_limit_r;
  logic [3:0] head_delay_r;
  logic [2:0] fpc_r;
  logic       cfg_wr;

  logic [3:0]  state_r, state_nxt;
  mwr_pkg::in_item_t item_r, item_nxt;
  logic [5:0]  fill_r   [P];
  logic [5:0]  fill_nxt [P];
  logic [4:0]  rp_r     [P];
  logic [4:0]  rp_nxt   [P];
  logic [5:0]  credit_r   [P];
  logic [5:0]  credit_nxt [P];
  logic [2:0]  rr_r     [P];
  logic [2:0]  rr_nxt   [P];
  logic [3:0]  owner_r    [P];
  logic [3:0]  owner_nxt  [P];
  logic [3:0]  route_r    [P];
  logic [3:0]  route_nxt  [P];
  logic        fhead_r    [P];
  logic        fhead_nxt  [P];
  logic        fready_r   [P];
  logic        fready_nxt [P];
  logic [2:0]  froute_r   [P];
  logic [2:0]  froute_nxt [P];
  logic [3:0]  sel_r      [P];
  logic [3:0]  sel_nxt    [P];
  logic [31:0] tick_r, tick_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [2:0]  sent_r, sent_nxt;
  logic [7:0]  fdest_r, fdest_nxt;
  logic [4:0]  rx_r, rx_nxt;
  logic [7:0]  ry_r, ry_nxt;
  logic        out_valid_r, out_valid_nxt;
  mwr_pkg::out_item_t out_r, out_nxt;

  logic       mem_we, mem_re;
  logic [mwr_pkg::MEM_AW-1:0] mem_waddr, mem_raddr;
  mwr_pkg::fentry_t mem_wdata, mem_q;
  logic       div_go, div_done;
  logic [7:0] div_a, div_q;
  logic [4:0] div_r;

  mwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (cols_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  mwr_fmem u_fmem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_q)
  );

  function automatic logic [2:0] mod5(input logic [3:0] v);
    mod5 = (v >= 4'd5) ? 3'(v - 4'd5) : v[2:0];
  endfunction

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_index_r <= 8'd0;
      cols_r         <= 5'd4;
      rows_r         <= 5'd4;
      buf_limit_r    <= 6'd32;
      head_delay_r   <= 4'd3;
      fpc_r          <= 3'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mwr_pkg::REG_ROUTER_INDEX: router_index_r <= pwdata[7:0];
        mwr_pkg::REG_COLUMNS:      cols_r         <= pwdata[4:0];
        mwr_pkg::REG_ROWS:         rows_r         <= pwdata[4:0];
        mwr_pkg::REG_BUF_LIMIT:    buf_limit_r    <= pwdata[5:0];
        mwr_pkg::REG_HEAD_DELAY:   head_delay_r   <= pwdata[3:0];
        mwr_pkg::REG_FPC:          fpc_r          <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mwr_pkg::REG_ROUTER_INDEX: prdata = {24'd0, router_index_r};
      mwr_pkg::REG_COLUMNS:      prdata = {27'd0, cols_r};
      mwr_pkg::REG_ROWS:         prdata = {27'd0, rows_r};
      mwr_pkg::REG_BUF_LIMIT:    prdata = {26'd0, buf_limit_r};
      mwr_pkg::REG_HEAD_DELAY:   prdata = {28'd0, head_delay_r};
      mwr_pkg::REG_FPC:          prdata = {29'd0, fpc_r};
      default:                   prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [5:0] cap;
    logic [5:0] room;
    logic [9:0] nodes;
    logic [2:0] budget;
    logic [2:0] ii;
    logic [2:0] cand;
    logic [2:0] base;
    logic [2:0] rt;
    logic       adv;
    state_nxt     = state_r;
    item_nxt      = item_r;
    fill_nxt      = fill_r;
    rp_nxt        = rp_r;
    credit_nxt    = credit_r;
    rr_nxt        = rr_r;
    owner_nxt     = owner_r;
    route_nxt     = route_r;
    fhead_nxt     = fhead_r;
    fready_nxt    = fready_r;
    froute_nxt    = froute_r;
    sel_nxt       = sel_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    sent_nxt      = sent_r;
    fdest_nxt     = fdest_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mem_we        = 1'b0;
    mem_waddr     = {item_r.port, 5'(rp_r[item_r.port] + fill_r[item_r.port][4:0])};
    mem_wdata.head  = item_r.is_head;
    mem_wdata.tail  = item_r.is_tail;
    mem_wdata.dest  = item_r.dest_node;
    mem_wdata.data  = item_r.payload;
    mem_wdata.stamp = tick_r + (item_r.is_head ? {28'd0, head_delay_r} : 32'd0);
    mem_re        = 1'b0;
    mem_raddr     = {idx_r, rp_r[idx_r]};
    div_go        = 1'b0;
    div_a         = router_index_r;
    cap    = (buf_limit_r < 6'(mwr_pkg::FIFO_DEPTH)) ? buf_limit_r : 6'(mwr_pkg::FIFO_DEPTH);
    nodes  = 10'(cols_r * rows_r);
    room   = 6'd0;
    budget = (fpc_r < 3'(mwr_pkg::MAX_BURST)) ? fpc_r : 3'(mwr_pkg::MAX_BURST);
    ii     = sel_r[idx_r][2:0];
    cand   = 3'd0;
    base   = 3'd0;
    rt     = 3'd0;
    adv    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = (in_item.opcode == mwr_pkg::OP_TICK) ? S_RDIV_GO : S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind  = mwr_pkg::KIND_EVENT;
        out_nxt.last  = 1'b1;
        if (item_r.port < 3'(P)) begin
          if (item_r.opcode == mwr_pkg::OP_FLIT) begin
            if (fill_r[item_r.port] >= cap) begin
              out_nxt.status = mwr_pkg::ST_OVERFLOW;
            end else if (item_r.is_head && ({2'd0, item_r.dest_node} >= nodes)) begin
              out_nxt.status = mwr_pkg::ST_BAD_DEST;
            end else begin
              mem_we = 1'b1;
              fill_nxt[item_r.port] = 6'(fill_r[item_r.port] + 6'd1);
            end
          end else if (item_r.opcode == mwr_pkg::OP_CREDIT) begin
            room = (buf_limit_r > credit_r[item_r.port])
                 ? 6'(buf_limit_r - credit_r[item_r.port]) : 6'd0;
            if (item_r.credit_count > room) begin
              out_nxt.status = mwr_pkg::ST_CREDIT;
            end else begin
              credit_nxt[item_r.port] = 6'(credit_r[item_r.port] + item_r.credit_count);
            end
          end
        end
        state_nxt = S_IDLE;
      end
      S_RDIV_GO: begin
        div_go    = 1'b1;
        state_nxt = S_RDIV_W;
      end
      S_RDIV_W: begin
        if (div_done) begin
          rx_nxt    = div_r;
          ry_nxt    = div_q;
          idx_nxt   = 3'd0;
          state_nxt = S_FRD;
        end
      end
      S_FRD: begin
        mem_re    = 1'b1;
        state_nxt = S_FCAP;
      end
      S_FCAP: begin
        fhead_nxt[idx_r]  = mem_q.head;
        fready_nxt[idx_r] = !(32'(tick_r - mem_q.stamp) >= 32'h8000_0000);
        fdest_nxt = mem_q.dest;
        div_a     = mem_q.dest;
        div_go    = 1'b1;
        state_nxt = S_FDIV_W;
      end
      S_FDIV_W: begin
        if (div_done) begin
          if (fdest_r == router_index_r) begin
            rt = mwr_pkg::LOCAL_PORT;
          end else if (div_r > rx_r) begin
            rt = 3'd0;
          end else if (div_r < rx_r) begin
            rt = 3'd1;
          end else begin
            rt = (div_q > ry_r) ? 3'd2 : 3'd3;
          end
          froute_nxt[idx_r] = rt;
          if (idx_r == 3'(P - 1)) begin
            state_nxt = S_SEL;
          end else begin
            idx_nxt   = 3'(idx_r + 3'd1);
            state_nxt = S_FRD;
          end
        end
      end
      S_SEL: begin
        for (int o = 0; o < P; o++) begin
          sel_nxt[o] = mwr_pkg::NO_PORT;
          if (owner_r[o] != mwr_pkg::NO_PORT) begin
            if (fill_r[owner_r[o][2:0]] != 6'd0) begin
              sel_nxt[o] = owner_r[o];
            end
          end else begin
            base = mod5({1'b0, rr_r[o]});
            for (int off = P; off >= 1; off--) begin
              cand = mod5(4'(base + 3'(off)));
              if (fill_r[cand] != 6'd0 && route_r[cand] == mwr_pkg::NO_PORT &&
                  fhead_r[cand] && fready_r[cand] && froute_r[cand] == 3'(o)) begin
                sel_nxt[o] = {1'b0, cand};
              end
            end
          end
        end
        idx_nxt   = 3'd0;
        state_nxt = S_OSTART;
      end
      S_OSTART: begin
        if (sel_r[idx_r] == mwr_pkg::NO_PORT || credit_r[idx_r] == 6'd0) begin
          adv = 1'b1;
        end else begin
          rr_nxt[idx_r] = ii;
          if (owner_r[idx_r] == mwr_pkg::NO_PORT) begin
            owner_nxt[idx_r] = {1'b0, ii};
            route_nxt[ii]    = {1'b0, idx_r};
          end
          sent_nxt  = 3'd0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sent_r < budget && credit_r[idx_r] != 6'd0 && fill_r[ii] != 6'd0) begin
          mem_re    = 1'b1;
          mem_raddr = {ii, rp_r[ii]};
          state_nxt = S_SCHK;
        end else begin
          adv = 1'b1;
        end
      end
      S_SCHK: begin
        if (32'(tick_r - mem_q.stamp) >= 32'h8000_0000) begin
          adv = 1'b1;
        end else begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = mwr_pkg::KIND_FLIT;
          out_nxt.out_port    = idx_r;
          out_nxt.credit_port = ii;
          out_nxt.out_payload = mem_q.data;
          out_nxt.out_dest    = mem_q.dest;
          out_nxt.out_head    = mem_q.head;
          out_nxt.out_tail    = mem_q.tail;
          rp_nxt[ii]          = 5'(rp_r[ii] + 5'd1);
          fill_nxt[ii]        = 6'(fill_r[ii] - 6'd1);
          credit_nxt[idx_r]   = 6'(credit_r[idx_r] - 6'd1);
          sent_nxt            = 3'(sent_r + 3'd1);
          if (mem_q.tail) begin
            owner_nxt[idx_r] = mwr_pkg::NO_PORT;
            route_nxt[ii]    = mwr_pkg::NO_PORT;
            adv = 1'b1;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_TEND: begin
        out_valid_nxt = 1'b1;
        out_nxt.kind  = mwr_pkg::KIND_TICK;
        out_nxt.last  = 1'b1;
        tick_nxt      = 32'(tick_r + 32'd1);
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      if (idx_r == 3'(P - 1)) begin
        state_nxt = S_TEND;
      end else begin
        idx_nxt   = 3'(idx_r + 3'd1);
        state_nxt = S_OSTART;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd0;
      idx_r       <= 3'd0;
      sent_r      <= 3'd0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < P; p++) begin
        fill_r[p]   <= 6'd0;
        rp_r[p]     <= 5'd0;
        credit_r[p] <= 6'd32;
        rr_r[p]     <= 3'(p);
        owner_r[p]  <= mwr_pkg::NO_PORT;
        route_r[p]  <= mwr_pkg::NO_PORT;
      end
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      rp_r        <= rp_nxt;
      credit_r    <= credit_nxt;
      rr_r        <= rr_nxt;
      owner_r     <= owner_nxt;
      route_r     <= route_nxt;
    end
    item_r   <= item_nxt;
    fhead_r  <= fhead_nxt;
    fready_r <= fready_nxt;
    froute_r <= froute_nxt;
    sel_r    <= sel_nxt;
    fdest_r  <= fdest_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`include "mesh_wormhole_router_unit_assert.svh"

  `MWR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `MWR_ASSERT(a_last_idle, !(out_valid_r && out_r.last) || state_r == S_IDLE,
              "last result while busy")
  `MWR_ASSERT(a_fill_bound, fill_r[0] <= 6'd32 && fill_r[1] <= 6'd32 &&
              fill_r[2] <= 6'd32 && fill_r[3] <= 6'd32 && fill_r[4] <= 6'd32,
              "fifo fill beyond depth")
  `MWR_ASSERT(a_owner_link,
              owner_r[0] == mwr_pkg::NO_PORT || route_r[owner_r[0][2:0]] == 4'd0,
              "east output owner not linked back")

endmodule
